FILE: rtl/gmd_pkg.sv
// gmd_pkg: shared constants, types and register indexes of the grid
// minimum-distance point filter; used by every module in rtl
package gmd_pkg;

    localparam int MAX_CELLS = 4096;
    localparam int CELL_AW = $clog2(MAX_CELLS);
    localparam int SLOTS_PER_CELL = 4;
    localparam int SLOT_W = $clog2(SLOTS_PER_CELL);
    localparam int FILL_W = $clog2(SLOTS_PER_CELL + 1);
    localparam int FRAC_BITS = 4;
    localparam int COORD_W = 16;
    localparam int PIX_W = COORD_W - FRAC_BITS;
    localparam int TAG_W = 8;
    localparam int GRID_W = 13;
    localparam int DIV_NW = 13;
    localparam int DIV_DW = 8;
    localparam int LIM_W = 2 * (DIV_DW + FRAC_BITS);
    localparam int KEPT_W = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FEATURES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_WRAP = 3'd4;

    localparam logic OP_TRACKED = 1'b0;
    localparam logic OP_NEW = 1'b1;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [FILL_W-1:0] fill;
        logic [SLOTS_PER_CELL-1:0][2*COORD_W-1:0] pts;
    } cell_row_t;

    localparam int ROW_W = $bits(cell_row_t);

    typedef struct packed {
        logic rd_valid;
        logic clear;
        logic [TAG_W-1:0] epoch;
    } dist_ctl_t;

endpackage

FILE: rtl/gmd_div.sv
// gmd_div: restoring divider, one quotient bit per cycle
// depends on gmd_pkg
module gmd_div
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [gmd_pkg::DIV_NW-1:0] dividend,
    input  logic [gmd_pkg::DIV_DW-1:0] divisor,
    output logic done,
    output logic [gmd_pkg::DIV_NW-1:0] quotient
);

    localparam int CNT_W = $clog2(gmd_pkg::DIV_NW);

    logic [gmd_pkg::DIV_DW-1:0] rem_reg;
    logic [gmd_pkg::DIV_DW-1:0] dvs_reg;
    logic [gmd_pkg::DIV_NW-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic run_reg;
    logic done_reg;
    logic [gmd_pkg::DIV_DW:0] trial;
    logic ge;
    logic [gmd_pkg::DIV_DW:0] diff;

    assign trial = {rem_reg, quo_reg[gmd_pkg::DIV_NW-1]};
    assign ge = trial >= {1'b0, dvs_reg};
    assign diff = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(gmd_pkg::DIV_NW - 1))
            begin
                run_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[gmd_pkg::DIV_DW-1:0] : trial[gmd_pkg::DIV_DW-1:0];
            quo_reg <= {quo_reg[gmd_pkg::DIV_NW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/gmd_cell_ram.sv
// gmd_cell_ram: one row per grid cell (epoch tag, fill count, stored points)
// depends on gmd_pkg; registered read data
module gmd_cell_ram
(
    input  logic clk,
    input  logic we,
    input  logic [gmd_pkg::CELL_AW-1:0] waddr,
    input  gmd_pkg::cell_row_t wdata,
    input  logic re,
    input  logic [gmd_pkg::CELL_AW-1:0] raddr,
    output gmd_pkg::cell_row_t rdata
);

    logic [gmd_pkg::ROW_W-1:0] mem [gmd_pkg::MAX_CELLS];
    logic [gmd_pkg::ROW_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/gmd_dist.sv
// gmd_dist: squared-distance check of one cell row, one lane per slot
// depends on gmd_pkg; three register stages, sticky hit flag
module gmd_dist
(
    input  logic clk,
    input  logic rst_n,
    input  gmd_pkg::dist_ctl_t ctl,
    input  gmd_pkg::cell_row_t row,
    input  logic [gmd_pkg::COORD_W-1:0] px,
    input  logic [gmd_pkg::COORD_W-1:0] py,
    input  logic [gmd_pkg::LIM_W-1:0] lim,
    output logic hit
);

    localparam int S = gmd_pkg::SLOTS_PER_CELL;
    localparam int CW = gmd_pkg::COORD_W;

    logic [S-1:0] sv;
    logic [S-1:0] sv1_reg;
    logic [S-1:0] sv2_reg;
    logic [S-1:0][CW-1:0] dx;
    logic [S-1:0][CW-1:0] dy;
    logic [S-1:0][CW-1:0] dx_reg;
    logic [S-1:0][CW-1:0] dy_reg;
    logic [S-1:0][2*CW-1:0] dxx_reg;
    logic [S-1:0][2*CW-1:0] dyy_reg;
    logic [S-1:0] close;
    logic hit_reg;

    always_comb
    begin
        for (int s = 0; s < S; s++)
        begin
            sv[s] = ctl.rd_valid && (row.tag == ctl.epoch)
                    && (gmd_pkg::FILL_W'(s) < row.fill);
            dx[s] = (px > row.pts[s][CW-1:0]) ? px - row.pts[s][CW-1:0]
                                               : row.pts[s][CW-1:0] - px;
            dy[s] = (py > row.pts[s][2*CW-1:CW]) ? py - row.pts[s][2*CW-1:CW]
                                                  : row.pts[s][2*CW-1:CW] - py;
            close[s] = sv2_reg[s]
                       && (({1'b0, dxx_reg[s]} + {1'b0, dyy_reg[s]})
                           < (2*CW+1)'(lim));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv1_reg <= '0;
            sv2_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            sv1_reg <= sv;
            sv2_reg <= sv1_reg;
            if (ctl.clear)
            begin
                hit_reg <= 1'b0;
            end
            else if (|close)
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < S; s++)
        begin
            dx_reg[s] <= dx[s];
            dy_reg[s] <= dy[s];
            dxx_reg[s] <= dx_reg[s] * dx_reg[s];
            dyy_reg[s] <= dy_reg[s] * dy_reg[s];
        end
    end

    assign hit = hit_reg;

endmodule

FILE: rtl/grid_min_distance_point_filter.sv
// grid_min_distance_point_filter: top level, control sequencer and registers
// depends on gmd_pkg, gmd_div, gmd_cell_ram, gmd_dist
//
// Input words carry one feature point each; tracked points of a frame come
// first, then new candidates, and the first word of a frame has
// first_of_frame set. Each input word gives exactly one output word.
// Both channels use valid/stall; a word moves when valid is high and stall
// is low. The output word sits in its own register, so a stalled receiver
// does not block the next input word from being taken.
// Sequence: a refused point (bad grid or cap) goes from the check state
// straight to the result state; a point that is tested goes through cell
// index division, the clamp and base setup states, one cell-memory read
// per neighbor cell (1 to 9), a drain of the distance pipeline, then the
// write-back and output.
// One point is in flight at a time; the next is taken after its result.
// A write of image width, height or minimum distance recomputes the grid,
// with input stalled meanwhile.
// After reset all 4096 rows of the cell memory are cleared, one row a cycle,
// with input stalled. Cells are tagged with an 8-bit frame epoch; every
// 256th frame start repeats that clearing pass before the point is handled.
module grid_min_distance_point_filter
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [gmd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gmd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic in_valid,
    output logic in_stall,
    input  logic opcode,
    input  logic first_of_frame,
    input  logic [15:0] x_pos,
    input  logic [15:0] y_pos,
    input  logic [15:0] point_id,
    input  logic [15:0] track_count,
    output logic out_valid,
    input  logic out_stall,
    output logic kept,
    output logic [15:0] x_out,
    output logic [15:0] y_out,
    output logic [15:0] id_out,
    output logic [15:0] track_count_out,
    output logic cap_reached,
    output logic config_error
);

    localparam int GW = gmd_pkg::GRID_W;
    localparam int AW = gmd_pkg::CELL_AW;
    localparam int TW = gmd_pkg::TAG_W;
    localparam int FW = gmd_pkg::FILL_W;
    localparam int KW = gmd_pkg::KEPT_W;
    localparam int MW = gmd_pkg::DIV_DW + gmd_pkg::FRAC_BITS;

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b000000000001,
        S_IDLE   = 12'b000000000010,
        S_GRID   = 12'b000000000100,
        S_GCHK   = 12'b000000001000,
        S_CHECK  = 12'b000000010000,
        S_DIV    = 12'b000000100000,
        S_CLAMP  = 12'b000001000000,
        S_BASE   = 12'b000010000000,
        S_SCAN   = 12'b000100000000,
        S_DRAIN  = 12'b001000000000,
        S_DECIDE = 12'b010000000000,
        S_RESULT = 12'b100000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [11:0] image_width_reg;
    logic [11:0] image_height_reg;
    logic [7:0] min_distance_reg;
    logic [9:0] max_features_reg;
    logic [15:0] id_wrap_reg;
    logic [GW-1:0] grid_cols_reg;
    logic [GW-1:0] grid_rows_reg;
    logic grid_bad_reg;
    logic grid_dirty_reg;
    logic [gmd_pkg::LIM_W-1:0] lim_reg;

    logic [TW-1:0] epoch_reg;
    logic [AW-1:0] clr_addr_reg;
    logic clr_item_reg;

    logic op_reg;
    logic [15:0] px_reg;
    logic [15:0] py_reg;
    logic [15:0] pid_reg;
    logic [15:0] pcnt_reg;
    logic [KW-1:0] kept_total_reg;
    logic [15:0] next_id_reg;

    logic [GW-1:0] cx_reg;
    logic [GW-1:0] cy_reg;
    logic [GW-1:0] x1_reg;
    logic [GW-1:0] x2_reg;
    logic [GW-1:0] y1_reg;
    logic [GW-1:0] y2_reg;
    logic [GW-1:0] prod_reg;
    logic [AW-1:0] own_addr_reg;
    logic [GW-1:0] row_base_reg;
    logic [GW-1:0] xx_reg;
    logic [GW-1:0] yy_reg;
    logic own_pend_reg;
    gmd_pkg::cell_row_t own_row_reg;
    logic [1:0] drain_reg;
    logic rd_valid_reg;

    logic res_kept_reg;
    logic res_cap_reg;
    logic res_err_reg;
    logic [15:0] res_id_reg;
    logic [15:0] res_cnt_reg;

    logic out_valid_reg;
    logic kept_reg;
    logic [15:0] x_out_reg;
    logic [15:0] y_out_reg;
    logic [15:0] id_out_reg;
    logic [15:0] cnt_out_reg;
    logic cap_reg;
    logic err_reg;

    logic in_accept;
    logic out_free;
    logic div_start;
    logic [gmd_pkg::DIV_NW-1:0] div_num_a;
    logic [gmd_pkg::DIV_NW-1:0] div_num_b;
    logic div_done_a;
    logic div_done_b;
    logic [gmd_pkg::DIV_NW-1:0] quo_a;
    logic [gmd_pkg::DIV_NW-1:0] quo_b;
    logic [GW-1:0] cx_clamp;
    logic [GW-1:0] cy_clamp;
    logic [2*GW-1:0] cells_prod;
    logic [2*GW-1:0] cy_prod;
    logic [2*MW-1:0] lim_prod;
    logic [MW-1:0] md_fx;
    logic ram_we;
    logic [AW-1:0] ram_waddr;
    gmd_pkg::cell_row_t ram_wdata;
    logic ram_re;
    logic [AW-1:0] ram_raddr;
    gmd_pkg::cell_row_t ram_rdata;
    gmd_pkg::cell_row_t new_row;
    logic [FW-1:0] fill_eff;
    logic dec_ok;
    logic dist_hit;
    gmd_pkg::dist_ctl_t dist_ctl;
    logic scan_last;
    logic [15:0] nid_inc;
    logic [15:0] nid_next;

    assign in_stall = !((state_reg == S_IDLE) && !grid_dirty_reg);
    assign in_accept = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign div_start = ((state_reg == S_IDLE) && grid_dirty_reg)
                       || ((state_reg == S_CHECK) && !grid_bad_reg
                           && !((op_reg == gmd_pkg::OP_NEW)
                                && (kept_total_reg >= {1'b0, max_features_reg})));
    assign div_num_a = (state_reg == S_IDLE)
        ? ({1'b0, image_width_reg} + {5'b0, min_distance_reg} - 13'd1)
        : {1'b0, px_reg[15:gmd_pkg::FRAC_BITS]};
    assign div_num_b = (state_reg == S_IDLE)
        ? ({1'b0, image_height_reg} + {5'b0, min_distance_reg} - 13'd1)
        : {1'b0, py_reg[15:gmd_pkg::FRAC_BITS]};

    gmd_div u_div_a
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .dividend(div_num_a),
        .divisor(min_distance_reg),
        .done(div_done_a),
        .quotient(quo_a)
    );

    gmd_div u_div_b
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .dividend(div_num_b),
        .divisor(min_distance_reg),
        .done(div_done_b),
        .quotient(quo_b)
    );

    assign cx_clamp = (quo_a > grid_cols_reg - 1'b1) ? grid_cols_reg - 1'b1 : quo_a;
    assign cy_clamp = (quo_b > grid_rows_reg - 1'b1) ? grid_rows_reg - 1'b1 : quo_b;
    assign cells_prod = grid_cols_reg * grid_rows_reg;
    assign cy_prod = cy_reg * grid_cols_reg;
    assign md_fx = {min_distance_reg, {gmd_pkg::FRAC_BITS{1'b0}}};
    assign lim_prod = md_fx * md_fx;

    assign fill_eff = (own_row_reg.tag == epoch_reg) ? own_row_reg.fill : '0;
    assign dec_ok = !dist_hit && (fill_eff < FW'(gmd_pkg::SLOTS_PER_CELL));

    always_comb
    begin
        new_row = own_row_reg;
        new_row.tag = epoch_reg;
        new_row.fill = fill_eff + 1'b1;
        new_row.pts[fill_eff[gmd_pkg::SLOT_W-1:0]] = {py_reg, px_reg};
    end

    assign ram_we = (state_reg == S_CLEAR) || ((state_reg == S_DECIDE) && dec_ok);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_addr_reg : own_addr_reg;
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 : new_row;
    assign ram_re = (state_reg == S_SCAN);
    assign ram_raddr = AW'(row_base_reg + xx_reg);
    assign scan_last = (xx_reg == x2_reg) && (yy_reg == y2_reg);

    gmd_cell_ram u_ram
    (
        .clk(clk),
        .we(ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re(ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign dist_ctl.rd_valid = rd_valid_reg;
    assign dist_ctl.clear = (state_reg == S_BASE);
    assign dist_ctl.epoch = epoch_reg;

    gmd_dist u_dist
    (
        .clk(clk),
        .rst_n(rst_n),
        .ctl(dist_ctl),
        .row(ram_rdata),
        .px(px_reg),
        .py(py_reg),
        .lim(lim_reg),
        .hit(dist_hit)
    );

    assign nid_inc = next_id_reg + 16'd1;
    assign nid_next = ((nid_inc >= id_wrap_reg) || (nid_inc == 16'd0)) ? 16'd0 : nid_inc;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == AW'(gmd_pkg::MAX_CELLS - 1))
                begin
                    state_next = clr_item_reg ? S_CHECK : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (grid_dirty_reg)
                begin
                    state_next = S_GRID;
                end
                else if (in_valid)
                begin
                    if (first_of_frame && (epoch_reg == {TW{1'b1}}))
                    begin
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_GRID:
            begin
                if (div_done_a)
                begin
                    state_next = S_GCHK;
                end
            end
            S_GCHK: state_next = S_IDLE;
            S_CHECK: state_next = div_start ? S_DIV : S_RESULT;
            S_DIV:
            begin
                if (div_done_b)
                begin
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP: state_next = S_BASE;
            S_BASE: state_next = S_SCAN;
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (drain_reg == 2'd3)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: state_next = S_RESULT;
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            image_width_reg <= 12'd640;
            image_height_reg <= 12'd480;
            min_distance_reg <= 8'd30;
            max_features_reg <= 10'd150;
            id_wrap_reg <= 16'd1024;
            grid_cols_reg <= '0;
            grid_rows_reg <= '0;
            grid_bad_reg <= 1'b1;
            grid_dirty_reg <= 1'b1;
            lim_reg <= '0;
            epoch_reg <= '0;
            clr_addr_reg <= '0;
            clr_item_reg <= 1'b0;
            kept_total_reg <= '0;
            next_id_reg <= '0;
            own_pend_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
            drain_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            own_pend_reg <= ram_re && (ram_raddr == own_addr_reg);
            rd_valid_reg <= ram_re;

            if (state_reg == S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end

            if ((state_reg == S_IDLE) && grid_dirty_reg)
            begin
                grid_dirty_reg <= 1'b0;
            end

            if (in_accept && first_of_frame)
            begin
                kept_total_reg <= '0;
                if (epoch_reg == {TW{1'b1}})
                begin
                    epoch_reg <= '0;
                    clr_addr_reg <= '0;
                    clr_item_reg <= 1'b1;
                end
                else
                begin
                    epoch_reg <= epoch_reg + 1'b1;
                end
            end

            if ((state_reg == S_GRID) && div_done_a)
            begin
                grid_cols_reg <= (min_distance_reg == 8'd0) ? '0 : quo_a;
                grid_rows_reg <= (min_distance_reg == 8'd0) ? '0 : quo_b;
            end

            if (state_reg == S_GCHK)
            begin
                grid_bad_reg <= (min_distance_reg == 8'd0) || (grid_cols_reg == '0)
                                || (grid_rows_reg == '0)
                                || (cells_prod > (2*GW)'(gmd_pkg::MAX_CELLS));
                lim_reg <= lim_prod;
            end

            if (state_reg == S_DRAIN)
            begin
                drain_reg <= drain_reg + 1'b1;
            end
            else
            begin
                drain_reg <= '0;
            end

            if ((state_reg == S_DECIDE) && dec_ok)
            begin
                if (kept_total_reg != {KW{1'b1}})
                begin
                    kept_total_reg <= kept_total_reg + 1'b1;
                end
                if (op_reg == gmd_pkg::OP_NEW)
                begin
                    next_id_reg <= nid_next;
                end
            end

            if ((state_reg == S_RESULT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    gmd_pkg::CFG_IMAGE_WIDTH:
                    begin
                        image_width_reg <= cfg_data[11:0];
                        grid_dirty_reg <= 1'b1;
                    end
                    gmd_pkg::CFG_IMAGE_HEIGHT:
                    begin
                        image_height_reg <= cfg_data[11:0];
                        grid_dirty_reg <= 1'b1;
                    end
                    gmd_pkg::CFG_MIN_DISTANCE:
                    begin
                        min_distance_reg <= cfg_data[7:0];
                        grid_dirty_reg <= 1'b1;
                    end
                    gmd_pkg::CFG_MAX_FEATURES:
                    begin
                        max_features_reg <= cfg_data[9:0];
                    end
                    gmd_pkg::CFG_ID_WRAP:
                    begin
                        id_wrap_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // item payload and scan registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg <= opcode;
            px_reg <= x_pos;
            py_reg <= y_pos;
            pid_reg <= point_id;
            pcnt_reg <= track_count;
        end

        if (state_reg == S_CHECK)
        begin
            res_kept_reg <= 1'b0;
            res_id_reg <= '0;
            res_cnt_reg <= '0;
            res_err_reg <= grid_bad_reg;
            res_cap_reg <= !grid_bad_reg && (op_reg == gmd_pkg::OP_NEW)
                           && (kept_total_reg >= {1'b0, max_features_reg});
        end

        if ((state_reg == S_DIV) && div_done_b)
        begin
            cx_reg <= cx_clamp;
            cy_reg <= cy_clamp;
        end

        if (state_reg == S_CLAMP)
        begin
            x1_reg <= (cx_reg != '0) ? cx_reg - 1'b1 : '0;
            y1_reg <= (cy_reg != '0) ? cy_reg - 1'b1 : '0;
            x2_reg <= (cx_reg + 1'b1 < grid_cols_reg) ? cx_reg + 1'b1 : grid_cols_reg - 1'b1;
            y2_reg <= (cy_reg + 1'b1 < grid_rows_reg) ? cy_reg + 1'b1 : grid_rows_reg - 1'b1;
            prod_reg <= cy_prod[GW-1:0];
        end

        if (state_reg == S_BASE)
        begin
            own_addr_reg <= AW'(prod_reg + cx_reg);
            row_base_reg <= (cy_reg != '0) ? prod_reg - grid_cols_reg : prod_reg;
            xx_reg <= x1_reg;
            yy_reg <= y1_reg;
        end

        if (state_reg == S_SCAN)
        begin
            if (xx_reg == x2_reg)
            begin
                xx_reg <= x1_reg;
                yy_reg <= yy_reg + 1'b1;
                row_base_reg <= row_base_reg + grid_cols_reg;
            end
            else
            begin
                xx_reg <= xx_reg + 1'b1;
            end
        end

        if (own_pend_reg)
        begin
            own_row_reg <= ram_rdata;
        end

        if ((state_reg == S_DECIDE) && dec_ok)
        begin
            res_kept_reg <= 1'b1;
            res_id_reg <= (op_reg == gmd_pkg::OP_NEW) ? next_id_reg : pid_reg;
            res_cnt_reg <= (op_reg == gmd_pkg::OP_NEW) ? 16'd1 : pcnt_reg;
        end

        if ((state_reg == S_RESULT) && out_free)
        begin
            kept_reg <= res_kept_reg;
            x_out_reg <= px_reg;
            y_out_reg <= py_reg;
            id_out_reg <= res_id_reg;
            cnt_out_reg <= res_cnt_reg;
            cap_reg <= res_cap_reg;
            err_reg <= res_err_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign kept = kept_reg;
    assign x_out = x_out_reg;
    assign y_out = y_out_reg;
    assign id_out = id_out_reg;
    assign track_count_out = cnt_out_reg;
    assign cap_reached = cap_reg;
    assign config_error = err_reg;

`ifndef SYNTH
    a_kept_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kept) |-> (!cap_reached && !config_error))
        else $error("kept word also flags a refusal");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DECIDE) && dec_ok) |=>
        ((kept_total_reg == $past(kept_total_reg) + 1'b1)
         || ($past(kept_total_reg) == {KW{1'b1}})))
        else $error("kept count did not advance on a stored point");

    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_RESULT))
        else $error("output word raised outside result state");
`endif

endmodule
